FILE: hw/rtl/stack_with_keyed_removal_assert.svh
// Assertion macros shared by the keyed-removal stack RTL.
`ifndef STACK_WITH_KEYED_REMOVAL_ASSERT_SVH
`define STACK_WITH_KEYED_REMOVAL_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define SWKR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SWKR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/swkr_pkg.sv
// Shared constants and types for the keyed-removal stack.
package swkr_pkg;

  // Default geometry
  localparam int unsigned DEPTH_DEF    = 16;
  localparam int unsigned KEY_BITS_DEF = 56;

  // Width of the occupancy field on the response
  localparam int unsigned OCC_W = 5;

  // Operation codes
  localparam logic OP_PUSH   = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Status codes
  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  // Per-cell control from the stack controller
  typedef struct packed {
    logic occupied;  // cell lies below the current count
    logic load;      // take the key as a new top entry
    logic shift;     // take the entry of the cell above
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/swkr_cell.sv
// One stack cell: holds an entry, compares it with the key, shifts down on removal.
module swkr_cell #(
  parameter int unsigned KEY_BITS = 56
) (
  input  logic                 clk,
  input  swkr_pkg::cell_ctrl_t ctrl,
  input  logic [KEY_BITS-1:0]  key,
  input  logic [KEY_BITS-1:0]  upper,
  output logic [KEY_BITS-1:0]  entry,
  output logic                 match
);
  import swkr_pkg::*;

  // Register the compare result for the controller
  always_ff @(posedge clk) begin
    match <= ctrl.occupied && (entry == key);
  end

  // Load a pushed key or take the neighbor above during compaction
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      entry <= key;
    end else if (ctrl.shift) begin
      entry <= upper;
    end
  end

endmodule

FILE: hw/rtl/stack_with_keyed_removal.sv
// Top level of the LIFO stack with delete-by-key.
// A request (operation, key) is accepted and then committed: in the accept cycle
// every cell compares its entry with the key in parallel and registers the
// result; in the next cycle the controller finds the topmost match and either
// loads the key into the cell at the current count (push) or shifts every cell
// from the match upward down by one (remove), then writes the response register.
// The next request is accepted in the cycle after the commit, so requests never
// overlap; a stalled response holds the controller in its commit cycle until
// the response register can take the new result. Cell storage needs no clearing
// after reset: only cells below the count are ever compared.
module stack_with_keyed_removal #(
  parameter int unsigned DEPTH    = swkr_pkg::DEPTH_DEF,
  parameter int unsigned KEY_BITS = swkr_pkg::KEY_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic                       operation,
  input  logic [KEY_BITS-1:0]        key,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output logic                       status,
  output logic                       found,
  output logic [swkr_pkg::OCC_W-1:0] occupancy
);
  import swkr_pkg::*;

  `include "stack_with_keyed_removal_assert.svh"

  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_CMP  = 2'b10
  } state_t;

  state_t              state;
  state_t              state_next;
  logic                op_reg;
  logic [KEY_BITS-1:0] key_reg;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [KEY_BITS-1:0] cmp_key;
  logic                commit;
  logic                full;
  logic                empty;
  logic                found_any;
  logic                status_next;
  logic                found_next;
  logic [CW+OCC_W-1:0] occ_ext;
  logic                remove_hit;
  logic                ctl_clear;

  logic [DEPTH-1:0]    match;
  logic [DEPTH-1:0]    above;
  logic [KEY_BITS-1:0] entry [DEPTH];
  cell_ctrl_t          ctrl  [DEPTH];

  // Handshake
  assign req_stall = (state != S_IDLE);
  assign commit    = (state == S_CMP) && (!rsp_valid || !rsp_stall);

  // Cells compare against the incoming key on accept, the held key while waiting
  assign cmp_key = (state == S_IDLE) ? key : key_reg;

  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign found_any = |match;

  // Build the cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_top
      assign above[i] = 1'b0;
      swkr_cell #(.KEY_BITS(KEY_BITS)) u_cell (
        .clk  (clk),
        .ctrl (ctrl[i]),
        .key  (cmp_key),
        .upper(entry[i]),
        .entry(entry[i]),
        .match(match[i])
      );
    end else begin : g_mid
      assign above[i] = |match[DEPTH-1:i+1];
      swkr_cell #(.KEY_BITS(KEY_BITS)) u_cell (
        .clk  (clk),
        .ctrl (ctrl[i]),
        .key  (cmp_key),
        .upper(entry[i+1]),
        .entry(entry[i]),
        .match(match[i])
      );
    end

    // Drive per-cell control: shift every cell at or above the topmost match
    assign ctrl[i].occupied = (CW'(i) < count);
    assign ctrl[i].load     = commit && (op_reg == OP_PUSH) && !full && (count == CW'(i));
    assign ctrl[i].shift    = commit && (op_reg == OP_REMOVE) && found_any && !above[i];
  end

  // Work out the result and the new count
  always_comb begin
    count_next  = count;
    status_next = ST_OK;
    found_next  = 1'b0;
    unique case (op_reg)
      OP_PUSH: begin
        if (full) begin
          status_next = ST_FAIL;
        end else begin
          count_next = count + CW'(1);
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          status_next = ST_FAIL;
        end else if (found_any) begin
          count_next = count - CW'(1);
          found_next = 1'b1;
        end
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  assign occ_ext = {{OCC_W{1'b0}}, count_next};

  // Sequence accept and commit
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (req_valid) state_next = S_CMP;
      S_CMP:   if (commit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Capture the request and the response payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      op_reg  <= operation;
      key_reg <= key;
    end
    if (commit) begin
      status    <= status_next;
      found     <= found_next;
      occupancy <= occ_ext[OCC_W-1:0];
    end
  end

  // Conditions watched by the checks
  assign remove_hit = commit && (op_reg == OP_REMOVE) && found_any;
  assign ctl_clear  = (state == S_IDLE) && !rsp_valid && (count == '0);

  // Checks on the controller
  `SWKR_ASSERT(a_count_bound, count <= CW'(DEPTH), "stack count exceeds depth")
  `SWKR_ASSERT(a_found_ok, rsp_valid |-> !(found && status), "found reported with failure")
  `SWKR_ASSERT(a_rm_dec, remove_hit |=> count == $past(count) - CW'(1), "remove hit kept count")
  `SWKR_ASSERT_ALWAYS(a_reset_idle, rst |=> ctl_clear, "reset did not clear control")

endmodule
